FILE: rtl/lpr_pkg.sv
// shared types and constants of the lookup-table pixel remap block
package lpr_pkg;

	localparam int MAX_PIXELS = 65536;
	localparam int IDX_W      = $clog2(MAX_PIXELS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int OFF_W      = 32;
	localparam int PIX_W      = 24;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef enum logic [1:0] {
		OP_WRITE_ENTRY = 2'd0,
		OP_WRITE_PIXEL = 2'd1,
		OP_READ_PIXEL  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		REG_PIXEL_COUNT  = 2'd0,
		REG_GRAY_MODE    = 2'd1,
		REG_BLANK_MARKER = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic             blank;
		logic [IDX_W-1:0] offset;
	} entry_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
		logic             ok;
		logic [IDX_W-1:0] src;
	} lookup_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [PIX_W-1:0] pixel;
		logic             blank;
	} result_t;

endpackage

FILE: rtl/lut_pixel_remap.sv
// top level of the lookup-table nearest-neighbour pixel remap block
//
// input channel (in_valid/in_ready): one request per cycle, while in_ready is high,
// carries op, pixel_index, source_offset and pixel_value. a table-entry write or a
// source-pixel write takes effect at the edge it is accepted and gives no result;
// a read request gives one result on the output channel (out_valid/out_ready).
// path of a read: a registered remap table read, then a registered source frame
// read, then the write into the result queue, after which out_valid rises.
// throughput: one request per clock while in_ready is high, set by the single
// read port of each memory; writes and reads interleave freely at that rate.
// a four-entry result queue absorbs the read pipeline; in_ready drops only when
// every queue slot is taken by a waiting result or a read still in flight, so
// a stalled receiver backs the input up after four outstanding reads.
// configuration writes (cfg_we) are taken every cycle with no handshake.
// reset clears the handshake state and loads the register defaults; the memories
// are not cleared, an entry must be written before it is read.
module lut_pixel_remap (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [31:0]              cfg_wdata,
	// input channel
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               op,
	input  logic [lpr_pkg::IDX_W-1:0] pixel_index,
	input  logic [lpr_pkg::OFF_W-1:0] source_offset,
	input  logic [lpr_pkg::PIX_W-1:0] pixel_value,
	// output channel
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [lpr_pkg::IDX_W-1:0] out_index,
	output logic [lpr_pkg::PIX_W-1:0] out_pixel,
	output logic                     out_blank
);

	logic [lpr_pkg::CNT_W-1:0] pixel_count_q;
	logic                     gray_mode_q;
	logic [lpr_pkg::OFF_W-1:0] blank_marker_q;
	logic [lpr_pkg::CNT_W-1:0] frame_n;

	logic                     accept;
	logic                     acc_entry;
	logic                     acc_pixel;
	logic                     acc_read;
	logic                     pop;
	logic [lpr_pkg::FIFO_AW:0] credit_q;

	lpr_pkg::lookup_t lookup;
	logic             res_valid;
	lpr_pkg::result_t res;
	logic             head_valid;
	lpr_pkg::result_t head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q  <= lpr_pkg::CNT_W'(lpr_pkg::MAX_PIXELS);
			gray_mode_q    <= 1'b0;
			blank_marker_q <= '1;
		end else if (cfg_we) begin
			unique case (lpr_pkg::reg_index_t'(cfg_index))
				lpr_pkg::REG_PIXEL_COUNT:  pixel_count_q  <= cfg_wdata[lpr_pkg::CNT_W-1:0];
				lpr_pkg::REG_GRAY_MODE:    gray_mode_q    <= cfg_wdata[0];
				lpr_pkg::REG_BLANK_MARKER: blank_marker_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// frame size clipped to the memory depth
	assign frame_n = (pixel_count_q > lpr_pkg::CNT_W'(lpr_pkg::MAX_PIXELS)) ?
		lpr_pkg::CNT_W'(lpr_pkg::MAX_PIXELS) : pixel_count_q;

	// request decode, the unused op code is accepted and dropped
	assign accept = in_valid && in_ready;
	always_comb begin
		acc_entry = 1'b0;
		acc_pixel = 1'b0;
		acc_read  = 1'b0;
		unique case (lpr_pkg::op_t'(op))
			lpr_pkg::OP_WRITE_ENTRY: acc_entry = accept;
			lpr_pkg::OP_WRITE_PIXEL: acc_pixel = accept;
			lpr_pkg::OP_READ_PIXEL:  acc_read  = accept;
			default: ;
		endcase
	end

	// slot credits: results queued plus reads still in the memory pipeline
	assign pop      = out_valid && out_ready;
	assign in_ready = (credit_q != (lpr_pkg::FIFO_AW+1)'(lpr_pkg::FIFO_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (acc_read && !pop) begin
			credit_q <= credit_q + 1'b1;
		end else if (pop && !acc_read) begin
			credit_q <= credit_q - 1'b1;
		end
	end

	// stage 1: remap table lookup
	lpr_remap_table u_table (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (acc_entry),
		.rd_en        (acc_read),
		.idx          (pixel_index),
		.offset       (source_offset),
		.blank_marker (blank_marker_q),
		.frame_n      (frame_n),
		.lookup       (lookup)
	);

	// stage 2: gather from the source frame
	lpr_source_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (acc_pixel),
		.wr_idx    (pixel_index),
		.wr_pixel  (pixel_value),
		.frame_n   (frame_n),
		.gray_mode (gray_mode_q),
		.lookup    (lookup),
		.res_valid (res_valid),
		.res       (res)
	);

	// result queue decouples the receiver
	lpr_out_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_valid),
		.push_data  (res),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	assign out_valid = head_valid;
	assign out_index = head.idx;
	assign out_pixel = head.pixel;
	assign out_blank = head.blank;

	// checks
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= (lpr_pkg::FIFO_AW+1)'(lpr_pkg::FIFO_DEPTH))
		else $error("slot credit above queue depth");

	a_read_reaches_queue: assert property (@(posedge clk) disable iff (!arst_n)
		acc_read |-> ##2 res_valid)
		else $error("read request did not reach the result queue");

	a_result_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (credit_q != '0))
		else $error("result shown without a held slot");

	a_blank_is_black: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_blank) |-> (out_pixel == '0))
		else $error("blank result with a nonzero pixel");

endmodule

FILE: rtl/lpr_remap_table.sv
// remap table memory: entry writes and the first lookup stage
module lpr_remap_table (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic                     rd_en,
	input  logic [lpr_pkg::IDX_W-1:0] idx,
	input  logic [lpr_pkg::OFF_W-1:0] offset,
	input  logic [lpr_pkg::OFF_W-1:0] blank_marker,
	input  logic [lpr_pkg::CNT_W-1:0] frame_n,
	output lpr_pkg::lookup_t         lookup
);

	lpr_pkg::entry_t mem [lpr_pkg::MAX_PIXELS];
	lpr_pkg::entry_t wr_entry;
	lpr_pkg::entry_t rd_q;
	logic             valid_s1;
	logic [lpr_pkg::IDX_W-1:0] idx_s1;
	logic             inrange_s1;
	logic             idx_inrange;

	assign idx_inrange = {1'b0, idx} < frame_n;

	always_comb begin
		wr_entry.blank  = (offset == blank_marker) || (offset >= lpr_pkg::OFF_W'(frame_n));
		wr_entry.offset = wr_entry.blank ? '0 : offset[lpr_pkg::IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (wr_en && idx_inrange) begin
			mem[idx] <= wr_entry;
		end
		rd_q <= mem[idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1     <= idx;
		inrange_s1 <= idx_inrange;
	end

	// a shrunk frame can leave a stored offset outside, treat it as blank
	always_comb begin
		lookup.valid = valid_s1;
		lookup.idx   = idx_s1;
		lookup.src   = rd_q.offset;
		lookup.ok    = inrange_s1 && !rd_q.blank && ({1'b0, rd_q.offset} < frame_n);
	end

endmodule

FILE: rtl/lpr_source_frame.sv
// source frame memory: pixel writes and the gather stage
module lpr_source_frame (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [lpr_pkg::IDX_W-1:0] wr_idx,
	input  logic [lpr_pkg::PIX_W-1:0] wr_pixel,
	input  logic [lpr_pkg::CNT_W-1:0] frame_n,
	input  logic                     gray_mode,
	input  lpr_pkg::lookup_t         lookup,
	output logic                     res_valid,
	output lpr_pkg::result_t         res
);

	logic [lpr_pkg::PIX_W-1:0] mem [lpr_pkg::MAX_PIXELS];
	logic [lpr_pkg::PIX_W-1:0] rd_q;
	logic                     valid_s2;
	logic [lpr_pkg::IDX_W-1:0] idx_s2;
	logic                     ok_s2;

	// read before write: a later pixel write never reaches an earlier lookup
	always_ff @(posedge clk) begin
		if (wr_en && ({1'b0, wr_idx} < frame_n)) begin
			mem[wr_idx] <= wr_pixel;
		end
		rd_q <= mem[lookup.src];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= lookup.valid;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2 <= lookup.idx;
		ok_s2  <= lookup.ok;
	end

	always_comb begin
		res_valid = valid_s2;
		res.idx   = idx_s2;
		res.blank = !ok_s2;
		if (!ok_s2) begin
			res.pixel = '0;
		end else if (gray_mode) begin
			res.pixel = {{(lpr_pkg::PIX_W-8){1'b0}}, rd_q[7:0]};
		end else begin
			res.pixel = rd_q;
		end
	end

endmodule

FILE: rtl/lpr_out_fifo.sv
// small result queue in front of the output port
module lpr_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lpr_pkg::result_t push_data,
	input  logic             pop,
	output logic             head_valid,
	output lpr_pkg::result_t head
);

	lpr_pkg::result_t           entries_q [lpr_pkg::FIFO_DEPTH];
	logic [lpr_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [lpr_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [lpr_pkg::FIFO_AW:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];

endmodule
